// ===== src/lorenz_pkg.sv =====
// shared types, constants and helper functions for the lorenz euler step block
package lorenz_pkg;

	localparam int FRAC_BITS_DEF = 24;

	localparam int POS_W      = 32;
	localparam int COEF_W     = 31;
	localparam int DT_W       = 25;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	// shared multiplier: magnitude operands and product
	localparam int A_W    = 40;
	localparam int B_W    = 32;
	localparam int PROD_W = A_W + B_W;
	localparam int ACC_W  = 64;

	localparam logic signed [ACC_W-1:0] DERIV_LIM = (ACC_W'(1) <<< 39) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] DERIV_NEG = -DERIV_LIM;
	localparam logic signed [ACC_W-1:0] POS_MAX   = ACC_W'(32'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] POS_MIN   = -POS_MAX - ACC_W'(1);

	// transaction opcodes
	localparam logic OP_STEP = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RHO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd3;

	// multiply sequence of one euler step
	localparam int STEP_COUNT  = 8;
	localparam int STEP_CODE_W = $clog2(STEP_COUNT);
	localparam logic [STEP_CODE_W-1:0] STEP_DX = 3'd0; // sigma*(y-x)
	localparam logic [STEP_CODE_W-1:0] STEP_RX = 3'd1; // rho*x - y
	localparam logic [STEP_CODE_W-1:0] STEP_XZ = 3'd2; // + x*z
	localparam logic [STEP_CODE_W-1:0] STEP_XY = 3'd3; // x*y
	localparam logic [STEP_CODE_W-1:0] STEP_BZ = 3'd4; // + beta*z
	localparam logic [STEP_CODE_W-1:0] STEP_TX = 3'd5; // x += dx*dt
	localparam logic [STEP_CODE_W-1:0] STEP_TY = 3'd6; // y += dy*dt
	localparam logic [STEP_CODE_W-1:0] STEP_TZ = 3'd7; // z -= dz*dt

	// allowance for the s1 and s2 registers between issue of a multiply and its accumulate
	localparam int PIPE_LAT = 2;
	localparam int RUN_LAST = STEP_COUNT + PIPE_LAT - 1;
	localparam int CNT_W    = $clog2(RUN_LAST + 1);

	typedef struct packed {
		logic                    op;
		logic signed [POS_W-1:0] load_x;
		logic signed [POS_W-1:0] load_y;
		logic signed [POS_W-1:0] load_z;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] out_x;
		logic signed [POS_W-1:0] out_y;
		logic signed [POS_W-1:0] out_z;
	} out_item_t;

	typedef struct packed {
		logic                   load;
		logic                   issue;
		logic [STEP_CODE_W-1:0] step;
		logic                   capture;
	} cmd_t;

	function automatic logic signed [A_W:0] clamp_deriv(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		begin
			if (v > DERIV_LIM) begin
				c = DERIV_LIM;
			end else if (v < DERIV_NEG) begin
				c = DERIV_NEG;
			end else begin
				c = v;
			end
			return c[A_W:0];
		end
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		begin
			if (v > POS_MAX) begin
				c = POS_MAX;
			end else if (v < POS_MIN) begin
				c = POS_MIN;
			end else begin
				c = v;
			end
			return c[POS_W-1:0];
		end
	endfunction

endpackage

// ===== src/lorenz_euler_step.sv =====
// lorenz euler step: top level, ties the controller to the datapath
// a load transaction replaces the point and goes straight to the done state; a step transaction
// first runs the multiply sequence; the result is registered once the output register is free
// a new transaction is taken only after the last result is captured; the eight products
// of a step share one 40x32 multiplier with a 3-stage operand/product/accumulate pipe
// reset: point cleared to zero, coefficients to 10, 28, 8/3 and dt to 0.003
module lorenz_euler_step #(
	parameter int FRAC_BITS = lorenz_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  lorenz_pkg::in_item_t                in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output lorenz_pkg::out_item_t               out_item,
	input  logic                                cfg_we,
	input  logic [lorenz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lorenz_pkg::CFG_DATA_W-1:0]   cfg_data
);

	lorenz_pkg::cmd_t cmd;

	lorenz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_op     (in_item.op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	lorenz_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_item  (out_item)
	);

endmodule

// ===== src/lorenz_dp.sv =====
// datapath: coefficients, point, shared multiplier pipeline and result register
module lorenz_dp #(
	parameter int FRAC_BITS = lorenz_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lorenz_pkg::cmd_t                       cmd,
	input  lorenz_pkg::in_item_t                   in_item,
	input  logic                                   cfg_we,
	input  logic [lorenz_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lorenz_pkg::CFG_DATA_W-1:0]      cfg_data,
	output lorenz_pkg::out_item_t                  out_item
);

	localparam int POS_W  = lorenz_pkg::POS_W;
	localparam int COEF_W = lorenz_pkg::COEF_W;
	localparam int DT_W   = lorenz_pkg::DT_W;
	localparam int A_W    = lorenz_pkg::A_W;
	localparam int B_W    = lorenz_pkg::B_W;
	localparam int PROD_W = lorenz_pkg::PROD_W;
	localparam int ACC_W  = lorenz_pkg::ACC_W;
	localparam int SC_W   = lorenz_pkg::STEP_CODE_W;

	localparam logic [63:0] COEF_MAX  = 64'h7FFF_FFFF;
	localparam logic [63:0] SIGMA_RAW = 64'd10 << FRAC_BITS;
	localparam logic [63:0] RHO_RAW   = 64'd28 << FRAC_BITS;
	localparam logic [63:0] BETA_RAW  = ((64'd16 << FRAC_BITS) + 64'd3) / 64'd6;
	localparam logic [63:0] DT_RAW    = ((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000;
	localparam logic [COEF_W-1:0] SIGMA_RST =
		(SIGMA_RAW > COEF_MAX) ? COEF_MAX[COEF_W-1:0] : SIGMA_RAW[COEF_W-1:0];
	localparam logic [COEF_W-1:0] RHO_RST =
		(RHO_RAW > COEF_MAX) ? COEF_MAX[COEF_W-1:0] : RHO_RAW[COEF_W-1:0];
	localparam logic [COEF_W-1:0] BETA_RST =
		(BETA_RAW > COEF_MAX) ? COEF_MAX[COEF_W-1:0] : BETA_RAW[COEF_W-1:0];
	localparam logic [DT_W-1:0] DT_RST = DT_RAW[DT_W-1:0];
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

	logic [COEF_W-1:0] sigma_q, rho_q, beta_q;
	logic [DT_W-1:0]   dt_q;

	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_z_q;
	lorenz_pkg::out_item_t   out_q;

	// operand select
	logic signed [A_W:0] a_sv;
	logic signed [B_W:0] b_sv;
	logic [A_W-1:0]      a_mag;
	logic [B_W-1:0]      b_mag;
	logic                neg;

	logic            vld_s1, neg_s1;
	logic [SC_W-1:0] step_s1;
	logic [A_W-1:0]  a_mag_s1;
	logic [B_W-1:0]  b_mag_s1;

	logic              vld_s2, neg_s2;
	logic [SC_W-1:0]   step_s2;
	logic [PROD_W-1:0] prod_s2;

	// round and accumulate
	logic [PROD_W-1:0]       rnd;
	logic signed [ACC_W-1:0] mag;
	logic signed [ACC_W-1:0] base;
	logic                    sub;
	logic signed [ACC_W-1:0] sum;
	logic signed [POS_W-1:0] sum_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RST;
			rho_q   <= RHO_RST;
			beta_q  <= BETA_RST;
			dt_q    <= DT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lorenz_pkg::REG_SIGMA: sigma_q <= cfg_data[COEF_W-1:0];
				lorenz_pkg::REG_RHO:   rho_q   <= cfg_data[COEF_W-1:0];
				lorenz_pkg::REG_BETA:  beta_q  <= cfg_data[COEF_W-1:0];
				lorenz_pkg::REG_STEP:  dt_q    <= cfg_data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		a_sv = '0;
		b_sv = '0;
		case (cmd.step)
			lorenz_pkg::STEP_DX: begin
				a_sv = (A_W+1)'(pos_y_q) - (A_W+1)'(pos_x_q);
				b_sv = (B_W+1)'(sigma_q);
			end
			lorenz_pkg::STEP_RX: begin
				a_sv = (A_W+1)'(pos_x_q);
				b_sv = (B_W+1)'(rho_q);
			end
			lorenz_pkg::STEP_XZ: begin
				a_sv = (A_W+1)'(pos_x_q);
				b_sv = (B_W+1)'(pos_z_q);
			end
			lorenz_pkg::STEP_XY: begin
				a_sv = (A_W+1)'(pos_x_q);
				b_sv = (B_W+1)'(pos_y_q);
			end
			lorenz_pkg::STEP_BZ: begin
				a_sv = (A_W+1)'(pos_z_q);
				b_sv = (B_W+1)'(beta_q);
			end
			lorenz_pkg::STEP_TX: begin
				a_sv = lorenz_pkg::clamp_deriv(acc_x_q);
				b_sv = (B_W+1)'(dt_q);
			end
			lorenz_pkg::STEP_TY: begin
				a_sv = lorenz_pkg::clamp_deriv(acc_y_q);
				b_sv = (B_W+1)'(dt_q);
			end
			lorenz_pkg::STEP_TZ: begin
				a_sv = lorenz_pkg::clamp_deriv(acc_z_q);
				b_sv = (B_W+1)'(dt_q);
			end
			default: ;
		endcase
		a_mag = a_sv[A_W] ? A_W'(-a_sv) : a_sv[A_W-1:0];
		b_mag = b_sv[B_W] ? B_W'(-b_sv) : b_sv[B_W-1:0];
		neg   = a_sv[A_W] ^ b_sv[B_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		step_s1  <= cmd.step;
		neg_s1   <= neg;
		a_mag_s1 <= a_mag;
		b_mag_s1 <= b_mag;
		step_s2  <= step_s1;
		neg_s2   <= neg_s1;
		prod_s2  <= PROD_W'(a_mag_s1) * PROD_W'(b_mag_s1);
	end

	// round to nearest, ties away from zero, on the magnitude
	always_comb begin
		rnd  = (prod_s2 + RND_HALF) >> FRAC_BITS;
		mag  = {1'b0, rnd[ACC_W-2:0]};
		base = '0;
		sub  = neg_s2;
		case (step_s2)
			lorenz_pkg::STEP_DX: base = '0;
			lorenz_pkg::STEP_RX: base = -ACC_W'(pos_y_q);
			lorenz_pkg::STEP_XZ: base = acc_y_q;
			lorenz_pkg::STEP_XY: base = '0;
			lorenz_pkg::STEP_BZ: base = acc_z_q;
			lorenz_pkg::STEP_TX: base = ACC_W'(pos_x_q);
			lorenz_pkg::STEP_TY: base = ACC_W'(pos_y_q);
			lorenz_pkg::STEP_TZ: begin
				base = ACC_W'(pos_z_q);
				sub  = !neg_s2;
			end
			default: ;
		endcase
		sum     = sub ? base - mag : base + mag;
		sum_sat = lorenz_pkg::sat_pos(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (cmd.load) begin
			pos_x_q <= in_item.load_x;
			pos_y_q <= in_item.load_y;
			pos_z_q <= in_item.load_z;
		end else if (vld_s2) begin
			case (step_s2)
				lorenz_pkg::STEP_TX: pos_x_q <= sum_sat;
				lorenz_pkg::STEP_TY: pos_y_q <= sum_sat;
				lorenz_pkg::STEP_TZ: pos_z_q <= sum_sat;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			case (step_s2)
				lorenz_pkg::STEP_DX: acc_x_q <= sum;
				lorenz_pkg::STEP_RX,
				lorenz_pkg::STEP_XZ: acc_y_q <= sum;
				lorenz_pkg::STEP_XY,
				lorenz_pkg::STEP_BZ: acc_z_q <= sum;
				default: ;
			endcase
		end
		if (cmd.capture) begin
			out_q.out_x <= pos_x_q;
			out_q.out_y <= pos_y_q;
			out_q.out_z <= pos_z_q;
		end
	end

	assign out_item = out_q;

endmodule

// ===== src/lorenz_ctrl.sv =====
// controller: sequences the eight multiplies of a step and the output handshake
module lorenz_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_op,
	output logic             out_valid,
	input  logic             out_ready,
	output lorenz_pkg::cmd_t cmd
);

	localparam int CNT_W = lorenz_pkg::CNT_W;
	localparam int SC_W  = lorenz_pkg::STEP_CODE_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		accept      = in_valid && in_ready;
		out_free    = !out_valid_q || out_ready;
		cmd.load    = accept && (in_op == lorenz_pkg::OP_LOAD);
		cmd.issue   = (state_q == ST_RUN) && (cnt_q < CNT_W'(lorenz_pkg::STEP_COUNT));
		cmd.step    = cnt_q[SC_W-1:0];
		cmd.capture = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= (in_op == lorenz_pkg::OP_LOAD) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					// last accumulate lands on this edge
					if (cnt_q == CNT_W'(lorenz_pkg::RUN_LAST)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_capture_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before its transaction");

	a_issue_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (state_q == ST_RUN && !in_ready))
		else $error("multiply issued outside of a step");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result shown without finishing an item");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_DONE))
		else $error("load did not go straight to result");

endmodule

// ===== verif/lorenz_euler_step_checker.sv =====
// transaction checker for the lorenz euler step block: tracks the point and compares results
`timescale 1ns / 1ps
module lorenz_euler_step_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  lorenz_pkg::in_item_t                in_item,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  lorenz_pkg::out_item_t               out_item,
	input  logic                                cfg_we,
	input  logic [lorenz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lorenz_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                  errors,
	output int                                  pending,
	output int                                  steps,
	output int                                  loads
);

	localparam int FRAC = lorenz_pkg::FRAC_BITS_DEF;
	localparam longint DERIV_MAX = (longint'(1) << 39) - 1;
	localparam longint PT_MAX = 64'sd2147483647;
	localparam longint PT_MIN = -64'sd2147483648;
	localparam logic [30:0] SIGMA_RST = 31'(10 * (1 << FRAC));
	localparam logic [30:0] RHO_RST   = 31'(28 * (1 << FRAC));
	localparam logic [30:0] BETA_RST  = 31'(((16 << FRAC) + 3) / 6);
	localparam logic [24:0] DT_RST    = 25'(((3 << FRAC) + 500) / 1000);

	logic [30:0] sigma_q, rho_q, beta_q;
	logic [24:0] dt_q;
	longint px, py, pz;
	int results;
	lorenz_pkg::out_item_t point_q[$];

	// fixed-point product, rounded to nearest with ties away from zero
	function automatic longint fx_mul(longint a, longint b);
		logic [63:0] ma, mb;
		logic [127:0] prod;
		longint m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		prod = {64'd0, ma} * {64'd0, mb};
		prod = prod + (128'd1 << (FRAC - 1));
		m = longint'(prod >> FRAC);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic flag(string what, logic [31:0] want, logic [31:0] got);
		errors++;
		$display("mismatch at result %0d, %s: expected %h, got %h", results, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		longint sg, rh, bt, ts, dx, dy, dz;
		lorenz_pkg::out_item_t want;
		if (!arst_n) begin
			sigma_q = SIGMA_RST;
			rho_q = RHO_RST;
			beta_q = BETA_RST;
			dt_q = DT_RST;
			px = 0;
			py = 0;
			pz = 0;
			point_q.delete();
			errors = 0;
			pending = 0;
			steps = 0;
			loads = 0;
			results = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lorenz_pkg::REG_SIGMA: sigma_q = cfg_data;
					lorenz_pkg::REG_RHO: rho_q = cfg_data;
					lorenz_pkg::REG_BETA: beta_q = cfg_data;
					lorenz_pkg::REG_STEP: dt_q = cfg_data[24:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_item.op == lorenz_pkg::OP_LOAD) begin
					// load transaction: point replaced and echoed
					px = longint'(in_item.load_x);
					py = longint'(in_item.load_y);
					pz = longint'(in_item.load_z);
					loads++;
				end else begin
					sg = longint'({33'd0, sigma_q});
					rh = longint'({33'd0, rho_q});
					bt = longint'({33'd0, beta_q});
					ts = longint'({39'd0, dt_q});
					dx = clip(fx_mul(sg, py - px), -DERIV_MAX, DERIV_MAX);
					dy = clip(fx_mul(rh, px) - py + fx_mul(px, pz), -DERIV_MAX, DERIV_MAX);
					dz = clip(fx_mul(px, py) + fx_mul(bt, pz), -DERIV_MAX, DERIV_MAX);
					px = clip(px + fx_mul(dx, ts), PT_MIN, PT_MAX);
					py = clip(py + fx_mul(dy, ts), PT_MIN, PT_MAX);
					// z axis runs mirrored
					pz = clip(pz - fx_mul(dz, ts), PT_MIN, PT_MAX);
					steps++;
				end
				want.out_x = px[31:0];
				want.out_y = py[31:0];
				want.out_z = pz[31:0];
				point_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (point_q.size() == 0) begin
					flag("unexpected result, out_x", 32'd0, out_item.out_x);
				end else begin
					want = point_q.pop_front();
					if (out_item.out_x !== want.out_x) begin
						flag("out_x", want.out_x, out_item.out_x);
					end
					if (out_item.out_y !== want.out_y) begin
						flag("out_y", want.out_y, out_item.out_y);
					end
					if (out_item.out_z !== want.out_z) begin
						flag("out_z", want.out_z, out_item.out_z);
					end
				end
				results++;
			end
			pending = point_q.size();
		end
	end

endmodule

// ===== verif/lorenz_euler_step_test.sv =====
// top of the lorenz euler step testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module lorenz_euler_step_test;

	localparam int FRAC = lorenz_pkg::FRAC_BITS_DEF;
	localparam int ONE = 1 << FRAC;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT = 16;
	localparam int HOLD_CYCLES = 300;
	localparam logic [31:0] PT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] PT_MIN = 32'h8000_0000;
	localparam logic [30:0] COEF_MAX = 31'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	lorenz_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	lorenz_pkg::out_item_t out_item;
	logic cfg_we;
	logic [lorenz_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lorenz_pkg::CFG_DATA_W-1:0] cfg_data;

	int errors, pending, steps, loads;
	int tx_idle_pct = 34;
	int rx_idle_pct = 34;
	int settings_run = 1;
	int cycles = 0;
	bit hold_req = 1'b0;

	always #5 clk = ~clk;

	lorenz_euler_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lorenz_euler_step_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.steps(steps),
		.loads(loads)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic lorenz_pkg::in_item_t load_item(logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		lorenz_pkg::in_item_t it;
		it.op = lorenz_pkg::OP_LOAD;
		it.load_x = x;
		it.load_y = y;
		it.load_z = z;
		return it;
	endfunction

	// unused load fields carry random bits
	function automatic lorenz_pkg::in_item_t step_item();
		lorenz_pkg::in_item_t it;
		it = load_item($urandom, $urandom, $urandom);
		it.op = lorenz_pkg::OP_STEP;
		return it;
	endfunction

	// uniform value within +-span whole units
	function automatic logic [31:0] near(int span);
		return int'($urandom_range(2 * span * ONE)) - span * ONE;
	endfunction

	function automatic logic [31:0] corner();
		case ($urandom_range(4))
			0: return PT_MAX;
			1: return PT_MIN;
			2: return 32'd0;
			3: return 32'hFFFF_FFFF;
			default: return 32'd1;
		endcase
	endfunction

	function automatic lorenz_pkg::in_item_t random_load();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			return load_item(near(25), near(30), near(60));
		end else if (pick < 85) begin
			return load_item($urandom, $urandom, $urandom);
		end
		return load_item(corner(), corner(), corner());
	endfunction

	// offer one transaction, starting at a falling edge; returns at a falling edge
	task automatic send(lorenz_pkg::in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(logic [lorenz_pkg::CFG_IDX_W-1:0] idx,
			logic [lorenz_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic apply(logic [30:0] sg, logic [30:0] rh, logic [30:0] bt, logic [30:0] dt);
		settle();
		write_reg(lorenz_pkg::REG_SIGMA, sg);
		write_reg(lorenz_pkg::REG_RHO, rh);
		write_reg(lorenz_pkg::REG_BETA, bt);
		write_reg(lorenz_pkg::REG_STEP, dt);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// mostly a load followed by a run of steps, with some stray transactions mixed in
	task automatic run_random(int count);
		int sent, run;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 8) begin
				send(($urandom_range(1) != 0) ? random_load() : step_item());
				sent++;
			end else begin
				send(random_load());
				sent++;
				run = $urandom_range(1, 40);
				while (run > 0 && sent < count) begin
					send(step_item());
					sent++;
					run--;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// origin is a fixed point of the system
		send(step_item());
		send(load_item(ONE, ONE, ONE));
		repeat (3) send(step_item());
		// saturation of derivatives and coordinates
		send(load_item(PT_MAX, PT_MIN, PT_MAX));
		repeat (2) send(step_item());
		send(load_item(PT_MIN, PT_MIN, PT_MIN));
		send(step_item());
		send(load_item(PT_MAX, PT_MAX, PT_MAX));
		send(step_item());
		send(load_item(32'd0, PT_MAX, PT_MIN));
		send(step_item());
		// rounding of tiny negative products
		send(load_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send(step_item());
		send(load_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
		send(load_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		send(step_item());

		run_random(350);

		apply(COEF_MAX, COEF_MAX, COEF_MAX, 31'h7FFF_FFFF);
		run_random(150);

		apply(31'd0, 31'd0, 31'd0, 31'd0);
		run_random(120);

		// step size of exactly one
		apply(31'(10 * ONE), 31'(28 * ONE), 31'((16 * ONE + 3) / 6), 31'(ONE));
		run_random(150);

		apply(31'($urandom_range(20 * ONE)), 31'($urandom_range(50 * ONE)),
			31'($urandom_range(5 * ONE)), 31'($urandom_range(1, 1 << 20)));
		// long receiver hold-off while transactions keep coming
		hold_req = 1'b1;
		run_random(300);

		apply(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
		run_random(200);

		apply(31'(10 * ONE), 31'(28 * ONE), 31'((16 * ONE + 3) / 6), 31'd1);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(300);
		tx_idle_pct = 34;
		rx_idle_pct = 34;
		run_random(400);

		settle();
		$display("covered %0d step and %0d load transactions across %0d coefficient settings",
			steps, loads, settings_run);
		$display("settings spanned zero and full-scale coefficients, step sizes of one and up");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
